[src/ptts_pkg.sv]
// Shared types and codes for the periodic task tick scheduler.
package ptts_pkg;

   localparam int ACTION_W = 3;
   localparam int HANDLE_W = 8;
   localparam int PERIOD_W = 16;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE   = 3'd0,
      ACT_TICK     = 3'd1,
      ACT_DISPATCH = 3'd2,
      ACT_SUSPEND  = 3'd3,
      ACT_RESUME   = 3'd4,
      ACT_DELETE   = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // One command as it travels from the front end to the back end.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [HANDLE_W-1:0] task_handle;
      logic [PERIOD_W-1:0] period_ticks;
      logic [PRIO_W-1:0]   priority_level;
      logic [PERIOD_W-1:0] initial_delay;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

[src/ptts_front.sv]
// Front end: accept request items, normalize fields and push them into a command queue.
module ptts_front #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ptts_pkg::cmd_type     in_cmd,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ptts_pkg::cmd_type     out_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ptts_pkg::cmd_type    q_ff [DEPTH];
   logic [PW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]          cnt_ff, cnt_in;
   ptts_pkg::cmd_type    norm;
   logic                 push, pop;

   // Classify: zero period counts as one, unused actions stay as they are.
   always_comb begin
      norm = in_cmd;
      if (in_cmd.period_ticks == '0) begin
         norm.period_ticks = ptts_pkg::PERIOD_W'(1);
      end
   end

   assign in_ready  = (cnt_ff != (PW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH-1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH-1)) ? '0 : rd_ff + PW'(1);
      end
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= norm;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(DEPTH))
      else $error("command queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + (PW+1)'(1)))
      else $error("command queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (rd_ff == wr_ff))
      else $error("empty queue with pointers apart");

endmodule

[src/ptts_back.sv]
// Back end: task table, ready ring and the sequencer that carries out commands.
module ptts_back #(
   parameter int MAX_TASKS   = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  ptts_pkg::cmd_type         cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_handle,
   output logic                      rsp_got,
   output logic [2:0]                rsp_status,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_count
);

   localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int UW = $clog2(MAX_TASKS + 1);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_INSERT = 4'b0010,
      S_WALK   = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [15:0] period;
      logic [7:0]  prio;
      logic [15:0] countdown;
      logic        suspended;
   } entry_type;

   state_type          state_ff, state_in;
   entry_type          tab_ff [MAX_TASKS];
   logic [UW-1:0]      used_ff, used_in;
   logic [7:0]         fifo_ff [QUEUE_DEPTH];
   logic [QW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [UW-1:0]      pos_ff, pos_in;
   ptts_pkg::cmd_type  cur_ff, cur_in;
   logic [7:0]         oh_ff, oh_in;
   logic               og_ff, og_in;
   logic [2:0]         ost_ff, ost_in;
   logic               push_en;
   logic [7:0]         push_val;
   logic               tab_we;
   logic [TW-1:0]      tab_wa;
   entry_type          tab_wd;
   logic [MAX_TASKS-1:0] hit;
   logic [TW-1:0]      hit_idx;
   logic               hit_any;
   entry_type          walk_e, prev_e;

   assign cmd_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_handle = oh_ff;
   assign rsp_got    = og_ff;
   assign rsp_status = ost_ff;
   assign rsp_count  = fill_ff;

   // First matching live slot for suspend, resume and delete.
   always_comb begin
      hit_idx = '0;
      hit_any = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         hit[i] = (UW'(i) < used_ff) && (tab_ff[i].handle == cmd.task_handle);
      end
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = TW'(i);
            hit_any = 1'b1;
         end
      end
   end

   assign walk_e = tab_ff[pos_ff[TW-1:0]];
   assign prev_e = tab_ff[TW'(pos_ff - UW'(1))];

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      head_in  = head_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      oh_in    = oh_ff;
      og_in    = og_ff;
      ost_in   = ost_ff;
      push_en  = 1'b0;
      push_val = walk_e.handle;
      tab_we   = 1'b0;
      tab_wa   = pos_ff[TW-1:0];
      tab_wd   = walk_e;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd;
               oh_in  = '0;
               og_in  = 1'b0;
               ost_in = ptts_pkg::ST_OK;
               state_in = S_RESP;
               case (cmd.action)
                  ptts_pkg::ACT_CREATE: begin
                     if (used_ff >= UW'(MAX_TASKS)) begin
                        ost_in = ptts_pkg::ST_FULL;
                     end else begin
                        pos_in   = used_ff;
                        state_in = S_INSERT;
                     end
                  end
                  ptts_pkg::ACT_TICK: begin
                     pos_in   = '0;
                     state_in = S_WALK;
                  end
                  ptts_pkg::ACT_DISPATCH: begin
                     if (fill_ff == '0) begin
                        ost_in = ptts_pkg::ST_EMPTY;
                     end else begin
                        oh_in   = fifo_ff[head_ff];
                        og_in   = 1'b1;
                        head_in = (head_ff == QW'(QUEUE_DEPTH-1)) ? '0 : head_ff + QW'(1);
                     end
                  end
                  ptts_pkg::ACT_SUSPEND, ptts_pkg::ACT_RESUME, ptts_pkg::ACT_DELETE: begin
                     if (!hit_any) begin
                        ost_in = ptts_pkg::ST_NOT_FOUND;
                     end else begin
                        tab_we = 1'b1;
                        tab_wa = hit_idx;
                        tab_wd = tab_ff[hit_idx];
                        if (cmd.action == ptts_pkg::ACT_SUSPEND) begin
                           tab_wd.suspended = 1'b1;
                        end else if (cmd.action == ptts_pkg::ACT_RESUME) begin
                           tab_wd.suspended = 1'b0;
                        end else begin
                           tab_wd.handle = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INSERT: begin
            // Shift one larger-priority entry up per cycle, then drop the new task in.
            tab_we = 1'b1;
            tab_wa = pos_ff[TW-1:0];
            if (pos_ff != '0 && cur_ff.priority_level < prev_e.prio) begin
               tab_wd = prev_e;
               pos_in = pos_ff - UW'(1);
            end else begin
               tab_wd.handle    = cur_ff.task_handle;
               tab_wd.period    = cur_ff.period_ticks;
               tab_wd.prio      = cur_ff.priority_level;
               tab_wd.countdown = cur_ff.initial_delay;
               tab_wd.suspended = 1'b0;
               used_in  = used_ff + UW'(1);
               state_in = S_RESP;
            end
         end
         S_WALK: begin
            if (pos_ff >= used_ff) begin
               state_in = S_RESP;
            end else begin
               if (walk_e.handle != '0 && !walk_e.suspended) begin
                  tab_we = 1'b1;
                  if (walk_e.countdown == '0) begin
                     tab_wd.countdown = walk_e.period - 16'd1;
                     if (fill_ff >= FW'(QUEUE_DEPTH)) begin
                        ost_in = ptts_pkg::ST_OVERFLOW;
                     end else begin
                        push_en = 1'b1;
                     end
                  end else begin
                     tab_wd.countdown = walk_e.countdown - 16'd1;
                  end
               end
               pos_in = pos_ff + UW'(1);
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      tail_in = push_en ? ((tail_ff == QW'(QUEUE_DEPTH-1)) ? '0 : tail_ff + QW'(1)) : tail_ff;
      fill_in = fill_ff + FW'(push_en) - FW'(head_in != head_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      oh_ff  <= oh_in;
      og_ff  <= og_in;
      ost_ff <= ost_in;
      if (tab_we) begin
         tab_ff[tab_wa] <= tab_wd;
      end
      if (push_en) begin
         fifo_ff[tail_ff] <= push_val;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("ready ring fill beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_TASKS))
      else $error("task table count beyond size");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !(cmd_valid && cmd_ready))
      else $error("command taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_got) |-> (rsp_status == ptts_pkg::ST_OK))
      else $error("dispatch with error status");

endmodule

[src/periodic_task_tick_scheduler_core.sv]
// Top level of the periodic task tick scheduler core.
// A request item carries one command: create, tick, dispatch, suspend, resume or
// delete. The front end queues commands in a two-entry queue; the back end runs
// them one at a time against a priority-sorted task table and a ring of ready
// handles, and returns exactly one response item per request. Dispatch, suspend,
// resume, delete and full-table create answer straight from idle; create first
// shifts each entry with a larger priority up a slot to make room; tick walks
// every used table entry, updating one slot per cycle. A new request is taken
// while the previous response waits, up to the queue depth.
module periodic_task_tick_scheduler_core #(
   parameter int MAX_TASKS   = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], task_handle[10:3], period_ticks[26:11], priority_level[34:27],
   // initial_delay[50:35], zero fill to 56
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dispatched_handle[7:0], dispatched[8], status[11:9], ready_count[16:12],
   // zero fill to 24
   output logic [23:0] rsp_tdata
);

   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   ptts_pkg::cmd_type in_cmd, q_cmd;
   logic              q_valid, q_ready;
   logic [7:0]        r_handle;
   logic              r_got;
   logic [2:0]        r_status;
   logic [FW-1:0]     r_count;

   // Unpack the request fields.
   assign in_cmd.action         = req_tdata[2:0];
   assign in_cmd.task_handle    = req_tdata[10:3];
   assign in_cmd.period_ticks   = req_tdata[26:11];
   assign in_cmd.priority_level = req_tdata[34:27];
   assign in_cmd.initial_delay  = req_tdata[50:35];

   ptts_front #(.DEPTH(2)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   ptts_back #(.MAX_TASKS(MAX_TASKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_handle (r_handle),
      .rsp_got    (r_got),
      .rsp_status (r_status),
      .rsp_count  (r_count)
   );

   // Pack the response; ready_count is five bits wide on the port.
   assign rsp_tdata = {7'd0, 5'(r_count), r_status, r_got, r_handle};

endmodule
